// File: rtl/held_key_press_sequence_detector_assert.svh
// Assertion helpers for the held-key sequence detector
`ifndef HELD_KEY_PRESS_SEQUENCE_DETECTOR_ASSERT_SVH
`define HELD_KEY_PRESS_SEQUENCE_DETECTOR_ASSERT_SVH

// checked only while out of reset
`define HKPSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HKPSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hkpsd_pkg.sv
`timescale 1ns / 1ps

package hkpsd_pkg;

	localparam int NUM_STEPS  = 3;
	localparam int CODE_W     = 10;
	localparam int PRESS_W    = 4;
	localparam int STEP_W     = 2;
	localparam int COUNT_W    = 6;
	localparam int SLOTS      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 16;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

	// slot order in the down flags
	localparam int SLOT_HOLD = 0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_CODE      = 3'd0,
		REG_SEQ_KEY_FIRST  = 3'd1,
		REG_SEQ_KEY_SECOND = 3'd2,
		REG_SEQ_KEY_THIRD  = 3'd3,
		REG_PRESSES_FIRST  = 3'd4,
		REG_PRESSES_SECOND = 3'd5,
		REG_PRESSES_THIRD  = 3'd6,
		REG_EXTRA_KEY      = 3'd7
	} cfg_idx_t;

	localparam logic [CODE_W-1:0]  RST_HOLD_CODE      = 10'd114;
	localparam logic [CODE_W-1:0]  RST_SEQ_KEY_FIRST  = 10'd116;
	localparam logic [CODE_W-1:0]  RST_SEQ_KEY_SECOND = 10'd115;
	localparam logic [CODE_W-1:0]  RST_SEQ_KEY_THIRD  = 10'd116;
	localparam logic [PRESS_W-1:0] RST_PRESSES_FIRST  = 4'd9;
	localparam logic [PRESS_W-1:0] RST_PRESSES_SECOND = 4'd5;
	localparam logic [PRESS_W-1:0] RST_PRESSES_THIRD  = 4'd3;
	localparam logic [CODE_W-1:0]  RST_EXTRA_KEY      = 10'd172;

	typedef struct packed {
		logic [CODE_W-1:0]  hold_code;
		logic [CODE_W-1:0]  seq_key_first;
		logic [CODE_W-1:0]  seq_key_second;
		logic [CODE_W-1:0]  seq_key_third;
		logic [PRESS_W-1:0] presses_first;
		logic [PRESS_W-1:0] presses_second;
		logic [PRESS_W-1:0] presses_third;
		logic [CODE_W-1:0]  extra_watched_key;
	} cfg_t;

	typedef struct packed {
		logic [SLOTS-1:0]   down;
		logic [STEP_W-1:0]  step;
		logic [COUNT_W-1:0] count;
	} state_t;

	typedef struct packed {
		logic               trigger;
		logic               sequence_reset;
		logic [STEP_W-1:0]  step_now;
		logic [COUNT_W-1:0] count_now;
	} result_t;

endpackage

// File: rtl/held_key_press_sequence_detector.sv
`timescale 1ns / 1ps
// Held-key press sequence detector.
// Input stream s_*: one key event per item, key code in s_tdata, up/down in s_tuser.
// Output stream m_*: one result item per event, in order.
// Config port cfg_*: write enable, register index (0..7) and data; writes land on
// the clock edge. The user makes them only while no event is in flight;
// the block itself does not enforce this.
// An accepted event passes the input register, then the result register, before
// it is presented on m_*. The key state and counters are updated in the same
// cycle the result register loads. Throughput: one event per cycle while m_tready
// is high. The next event may be taken while a result is still waiting, since
// the input register and result register decouple the two sides.
// When m_tready is low the result is held, the input register fills and then
// s_tready drops; nothing is lost or repeated.
// Reset (arst_n low): config returns to defaults, all keys read as up, step and
// count clear, both streams empty. No clearing sweep is needed.
module held_key_press_sequence_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [hkpsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] event code, rest zero
	input  logic                                s_tuser,   // [0] pressed
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [hkpsd_pkg::M_TDATA_W-1:0]     m_tdata,   // [0] trigger, [1] sequence_reset,
	                                                       // [3:2] step_now, [9:4] count_now
	input  logic                                cfg_we,
	input  logic [hkpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hkpsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	hkpsd_pkg::cfg_t    cfg_q;
	hkpsd_pkg::state_t  state_q, state_nxt;
	hkpsd_pkg::result_t res_nxt, res_q;

	logic                          valid_s1;
	logic [hkpsd_pkg::CODE_W-1:0]  ev_code_s1;
	logic                          pressed_s1;
	logic                          out_valid_q;
	logic                          adv;
	logic                          fire;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_code         <= hkpsd_pkg::RST_HOLD_CODE;
			cfg_q.seq_key_first     <= hkpsd_pkg::RST_SEQ_KEY_FIRST;
			cfg_q.seq_key_second    <= hkpsd_pkg::RST_SEQ_KEY_SECOND;
			cfg_q.seq_key_third     <= hkpsd_pkg::RST_SEQ_KEY_THIRD;
			cfg_q.presses_first     <= hkpsd_pkg::RST_PRESSES_FIRST;
			cfg_q.presses_second    <= hkpsd_pkg::RST_PRESSES_SECOND;
			cfg_q.presses_third     <= hkpsd_pkg::RST_PRESSES_THIRD;
			cfg_q.extra_watched_key <= hkpsd_pkg::RST_EXTRA_KEY;
		end else if (cfg_we) begin
			case (cfg_index)
				hkpsd_pkg::REG_HOLD_CODE:      cfg_q.hold_code      <= cfg_data;
				hkpsd_pkg::REG_SEQ_KEY_FIRST:  cfg_q.seq_key_first  <= cfg_data;
				hkpsd_pkg::REG_SEQ_KEY_SECOND: cfg_q.seq_key_second <= cfg_data;
				hkpsd_pkg::REG_SEQ_KEY_THIRD:  cfg_q.seq_key_third  <= cfg_data;
				hkpsd_pkg::REG_PRESSES_FIRST: begin
					cfg_q.presses_first <= cfg_data[hkpsd_pkg::PRESS_W-1:0];
				end
				hkpsd_pkg::REG_PRESSES_SECOND: begin
					cfg_q.presses_second <= cfg_data[hkpsd_pkg::PRESS_W-1:0];
				end
				hkpsd_pkg::REG_PRESSES_THIRD: begin
					cfg_q.presses_third <= cfg_data[hkpsd_pkg::PRESS_W-1:0];
				end
				hkpsd_pkg::REG_EXTRA_KEY:      cfg_q.extra_watched_key <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_code_s1 <= s_tdata[hkpsd_pkg::CODE_W-1:0];
			pressed_s1 <= s_tuser;
		end
	end

	hkpsd_next u_next (
		.cfg      (cfg_q),
		.ev_code  (ev_code_s1),
		.pressed  (pressed_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(hkpsd_pkg::M_TDATA_W - 10){1'b0}}, res_q.count_now, res_q.step_now,
	                   res_q.sequence_reset, res_q.trigger};

	`include "held_key_press_sequence_detector_assert.svh"

	`HKPSD_ASSERT(a_trig_rearms, m_tvalid && res_q.trigger |-> res_q.count_now == '0 && res_q.step_now == '0 && !res_q.sequence_reset, "trigger without rearm")
	`HKPSD_ASSERT(a_count_needs_hold, state_q.count != $past(state_q.count) && state_q.count != '0 |-> $past(state_q.down[hkpsd_pkg::SLOT_HOLD]), "count moved without hold key down")
	`HKPSD_ASSERT(a_step_range, state_q.step <= hkpsd_pkg::LAST_STEP, "step beyond last")
	`HKPSD_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid, "result presented straight after reset")

endmodule

// File: rtl/hkpsd_next.sv
`timescale 1ns / 1ps

module hkpsd_next (
	input  hkpsd_pkg::cfg_t                  cfg,
	input  logic [hkpsd_pkg::CODE_W-1:0]     ev_code,
	input  logic                             pressed,
	input  hkpsd_pkg::state_t                cur,
	output hkpsd_pkg::state_t                nxt,
	output hkpsd_pkg::result_t               res
);

	logic [hkpsd_pkg::SLOTS-1:0]   match;
	logic                          watched;
	logic                          is_down;
	logic [hkpsd_pkg::STEP_W-1:0]  st;
	logic [hkpsd_pkg::CODE_W-1:0]  step_key;
	logic [hkpsd_pkg::COUNT_W-1:0] tot0, tot1, tot2;
	logic [hkpsd_pkg::COUNT_W-1:0] run_tot;
	logic [hkpsd_pkg::COUNT_W:0]   cnt_inc;
	logic                          adv_chk;
	logic                          trig, rst;
	logic [hkpsd_pkg::SLOTS-1:0]   down_n;
	logic [hkpsd_pkg::STEP_W-1:0]  step_n;
	logic [hkpsd_pkg::COUNT_W-1:0] cnt_n;

	always_comb begin
		match[0] = (ev_code == cfg.hold_code);
		match[1] = (ev_code == cfg.seq_key_first);
		match[2] = (ev_code == cfg.seq_key_second);
		match[3] = (ev_code == cfg.seq_key_third);
		match[4] = (ev_code == cfg.extra_watched_key);
		watched  = |match;
	end

	// hold slot decides on its own; otherwise first matching slot wins
	always_comb begin
		if (match[0]) begin
			is_down = cur.down[0];
		end else if (match[1]) begin
			is_down = cur.down[1];
		end else if (match[2]) begin
			is_down = cur.down[2];
		end else if (match[3]) begin
			is_down = cur.down[3];
		end else begin
			is_down = match[4] & cur.down[4];
		end
	end

	always_comb begin
		st = (cur.step > hkpsd_pkg::LAST_STEP) ? hkpsd_pkg::LAST_STEP : cur.step;
		case (st)
			2'd0:    step_key = cfg.seq_key_first;
			2'd1:    step_key = cfg.seq_key_second;
			default: step_key = cfg.seq_key_third;
		endcase
		tot0    = hkpsd_pkg::COUNT_W'(cfg.presses_first);
		tot1    = tot0 + hkpsd_pkg::COUNT_W'(cfg.presses_second);
		tot2    = tot1 + hkpsd_pkg::COUNT_W'(cfg.presses_third);
		cnt_inc = {1'b0, cur.count} + 1'b1;
	end

	always_comb begin
		down_n  = cur.down;
		step_n  = st;
		cnt_n   = cur.count;
		trig    = 1'b0;
		rst     = 1'b0;
		adv_chk = 1'b0;
		if (watched) begin
			if (pressed) begin
				if (!is_down) begin
					down_n = cur.down | match;
					if (!match[hkpsd_pkg::SLOT_HOLD] && cur.down[hkpsd_pkg::SLOT_HOLD]) begin
						adv_chk = 1'b1;
						if (ev_code == step_key) begin
							if (cnt_inc >= {1'b0, tot2}) begin
								trig    = 1'b1;
								cnt_n   = '0;
								step_n  = '0;
								adv_chk = 1'b0;
							end else begin
								cnt_n = cnt_inc[hkpsd_pkg::COUNT_W-1:0];
							end
						end else begin
							rst    = 1'b1;
							cnt_n  = '0;
							step_n = '0;
						end
					end
				end
			end else begin
				down_n = cur.down & ~match;
				if (match[hkpsd_pkg::SLOT_HOLD]) begin
					rst    = 1'b1;
					cnt_n  = '0;
					step_n = '0;
				end
			end
		end
		case (step_n)
			2'd0:    run_tot = tot0;
			2'd1:    run_tot = tot1;
			default: run_tot = tot2;
		endcase
		if (adv_chk && cnt_n == run_tot && step_n < hkpsd_pkg::LAST_STEP) begin
			step_n = step_n + 1'b1;
		end
	end

	assign nxt.down           = down_n;
	assign nxt.step           = step_n;
	assign nxt.count          = cnt_n;
	assign res.trigger        = trig;
	assign res.sequence_reset = rst;
	assign res.step_now       = step_n;
	assign res.count_now      = cnt_n;

endmodule
